>>> design/sawtc_pkg.sv
// Shared types and codes of the set-associative write-through cache.
// No dependencies; every other design file imports this package.
package sawtc_pkg;

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 3;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_RDATA = 2'd0,
        KIND_FETCH = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_BUSY  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_TAG,
        S_CMP,
        S_DATA,
        S_EMIT
    } t_state;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // Byte mask of the low len bytes, len already clamped to 0..4.
    function automatic logic [3:0] len_mask(input logic [LEN_W-1:0] len);
        logic [3:0] m;
        unique case (len)
            3'd0:    m = 4'b0000;
            3'd1:    m = 4'b0001;
            3'd2:    m = 4'b0011;
            3'd3:    m = 4'b0111;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

endpackage

>>> design/sawtc_ifs.sv
// Valid/ready channel interfaces of the cache: request, response, configuration.
// Depends on sawtc_pkg for field widths.
interface sawtc_req_if;
    import sawtc_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] fill_word;
    modport source (output valid, action, addr, len, wr_data, fill_word, input ready);
    modport sink   (input valid, action, addr, len, wr_data, fill_word, output ready);
endinterface

interface sawtc_rsp_if;
    import sawtc_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] out_addr;
    logic [LEN_W-1:0]  out_len;
    logic [DATA_W-1:0] out_data;
    modport source (output valid, kind, out_addr, out_len, out_data, input ready);
    modport sink   (input valid, kind, out_addr, out_len, out_data, output ready);
endinterface

interface sawtc_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/sawtc_data_ram.sv
// Line data store: one write port and one registered read port of 32-bit words.
// Depends on sawtc_pkg for the word width.
module sawtc_data_ram #(
    parameter int AW = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [sawtc_pkg::DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [sawtc_pkg::DATA_W-1:0] o_rdata
);
    import sawtc_pkg::*;

    logic [DATA_W-1:0] mem [1 << AW];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/sawtc_tag_ram.sv
// Tag store: one row per set holding every way's tag, written one way at a time.
// Depends on sawtc_pkg only through the import convention.
module sawtc_tag_ram #(
    parameter int SB = 7,
    parameter int NW = 8,
    parameter int WB = 3,
    parameter int TW = 19
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [SB-1:0]          i_wset,
    input  logic [WB-1:0]          i_wway,
    input  logic [TW-1:0]          i_wtag,
    input  logic                   i_re,
    input  logic [SB-1:0]          i_rset,
    output logic [NW-1:0][TW-1:0]  o_row
);
    import sawtc_pkg::*;

    logic [NW-1:0][TW-1:0] mem [1 << SB];
    logic [NW-1:0][TW-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wset][i_wway] <= i_wtag;
        end
        if (i_re) begin
            r_row <= mem[i_rset];
        end
    end

    assign o_row = r_row;
endmodule

>>> design/set_assoc_write_through_cache_core.sv
// Top level of the set-associative write-through, no-allocate cache.
// Depends on sawtc_pkg, sawtc_ifs, sawtc_data_ram and sawtc_tag_ram.
//
//  channel   dir  contents                                    taken when
//  i_req     in   action, addr, len, wr_data, fill_word       valid & ready
//  o_rsp     out  kind, out_addr, out_len, out_data           valid & ready
//  i_cfg     in   data = replace_mode                         valid & ready
//
// An access is split into one or two word segments. Each segment passes through
// S_TAG (tag and valid read), S_CMP (compare plus data read) and S_DATA (data
// merge or write), the last skipped when it misses, and S_EMIT then places the
// result in the output register. Fill words are taken one per cycle; the last
// one starts the retried read. Busy rejections go straight to S_EMIT. Reset is
// synchronous and starts a clearing pass that zeroes the valid bits of one set
// per cycle; requests wait for it, tags and data are left as they are. A full
// output register stalls only the S_EMIT state that would load it; a new item
// is still taken while a result waits to be collected.
module set_assoc_write_through_cache_core #(
    parameter int SET_BITS  = 7,
    parameter int WAY_BITS  = 3,
    parameter int LINE_BITS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sawtc_req_if.sink     i_req,
    sawtc_rsp_if.source   o_rsp,
    sawtc_cfg_if.sink     i_cfg
);
    import sawtc_pkg::*;

    localparam int NSETS     = 1 << SET_BITS;
    localparam int NWAYS     = 1 << WAY_BITS;
    localparam int WIDX      = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int WRD_W     = LINE_BITS - 2;
    localparam int TAG_SHIFT = SET_BITS + LINE_BITS;
    localparam int TAG_W     = ADDR_W - TAG_SHIFT;
    localparam int DA_W      = SET_BITS + WAY_BITS + WRD_W;

    function automatic logic [DA_W-1:0] mk_daddr(input logic [SET_BITS-1:0] s,
                                                 input logic [WIDX-1:0] w,
                                                 input logic [WRD_W-1:0] k);
        return (DA_W'(s) << (WAY_BITS + WRD_W)) | (DA_W'(w) << WRD_W) | DA_W'(k);
    endfunction

    // Control and item registers.
    t_state              r_state, n_state;
    logic                r_mode, n_mode;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [DATA_W-1:0]   r_wdata, n_wdata;
    logic                r_is_wr, n_is_wr;
    logic                r_seg, n_seg;
    logic [WIDX-1:0]     r_way, n_way;
    logic [DATA_W-1:0]   r_w0, n_w0;
    logic [SET_BITS-1:0] r_clr_set, n_clr_set;
    // Fill bookkeeping.
    logic                r_fill, n_fill;
    logic [ADDR_W-1:0]   r_fill_line, n_fill_line;
    logic [WRD_W-1:0]    r_fill_cnt, n_fill_cnt;
    logic [WIDX-1:0]     r_victim, n_victim;
    logic [NWAYS-1:0]    r_fill_vrow, n_fill_vrow;
    logic [15:0]         r_lfsr, n_lfsr;
    // Result waiting for the output register, and the output register itself.
    t_kind               r_res_kind, n_res_kind;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic [LEN_W-1:0]    r_res_len, n_res_len;
    logic [DATA_W-1:0]   r_res_data, n_res_data;
    logic                r_out_valid, n_out_valid;
    t_kind               r_out_kind, n_out_kind;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    logic [LEN_W-1:0]    r_out_len, n_out_len;
    logic [DATA_W-1:0]   r_out_data, n_out_data;

    // Valid bits, one row of ways per set, read together with the tag row.
    logic [NWAYS-1:0]    valid_mem [NSETS];
    logic [NWAYS-1:0]    r_vrow;

    // Memory ports.
    logic                tag_we, tag_re;
    logic [SET_BITS-1:0] tag_wset;
    logic [TAG_W-1:0]    tag_wtag;
    logic [NWAYS-1:0][TAG_W-1:0] tag_row;
    logic                dat_we, dat_re;
    logic [DA_W-1:0]     dat_waddr, dat_raddr;
    logic [DATA_W-1:0]   dat_wdata, dat_rdata;
    logic                vm_we;
    logic [SET_BITS-1:0] vm_waddr;
    logic [NWAYS-1:0]    vm_wrow;

    // Current segment geometry.
    logic [ADDR_W-1:0]   last_addr, seg_addr;
    logic                two_seg;
    logic [SET_BITS-1:0] cur_set, fill_set;
    logic [TAG_W-1:0]    cur_tag;
    logic [WRD_W-1:0]    cur_wrd;
    logic [NWAYS-1:0]    cur_v;
    logic                hit;
    logic [WIDX-1:0]     hit_way, free_way;
    logic                has_free;
    logic [15:0]         lfsr_step;
    logic [3:0]          len_bytes;
    logic [63:0]         wr_pair;
    logic [7:0]          wr_pmask;
    logic [63:0]         rd_pair;
    logic [DATA_W-1:0]   rd_mask;
    logic [3:0]          seg_mask;
    logic [DATA_W-1:0]   seg_new;
    logic [DATA_W-1:0]   merged;
    logic                out_free;
    logic                take;
    logic [LEN_W-1:0]    in_len;

    assign last_addr = r_addr + ADDR_W'(r_len) - ADDR_W'(1);
    assign two_seg   = last_addr[ADDR_W-1:2] != r_addr[ADDR_W-1:2];
    assign seg_addr  = r_seg ? {last_addr[ADDR_W-1:2], 2'b00} : {r_addr[ADDR_W-1:2], 2'b00};
    assign cur_set   = seg_addr[LINE_BITS +: SET_BITS];
    assign cur_tag   = seg_addr[ADDR_W-1:TAG_SHIFT];
    assign cur_wrd   = seg_addr[LINE_BITS-1:2];
    assign cur_v     = r_vrow;
    assign fill_set  = r_fill_line[LINE_BITS +: SET_BITS];
    assign lfsr_step = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};
    assign in_len    = (i_req.len > LEN_W'(4)) ? LEN_W'(4) : i_req.len;

    // Lowest hitting way, and lowest free way for a victim.
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        has_free = 1'b0;
        free_way = '0;
        for (int w = NWAYS - 1; w >= 0; w--) begin
            if (cur_v[w] && tag_row[w] == cur_tag) begin
                hit     = 1'b1;
                hit_way = WIDX'(w);
            end
            if (!cur_v[w]) begin
                has_free = 1'b1;
                free_way = WIDX'(w);
            end
        end
    end

    // Write data and byte mask laid over the two words an access can touch.
    assign len_bytes = len_mask(r_len);
    assign wr_pair   = 64'(r_wdata) << {r_addr[1:0], 3'b000};
    assign wr_pmask  = 8'(len_bytes) << r_addr[1:0];
    assign seg_new   = r_seg ? wr_pair[63:32] : wr_pair[31:0];
    assign seg_mask  = r_seg ? wr_pmask[7:4] : wr_pmask[3:0];
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            merged[8*b +: 8]  = seg_mask[b] ? seg_new[8*b +: 8] : dat_rdata[8*b +: 8];
            rd_mask[8*b +: 8] = {8{len_bytes[b]}};
        end
    end
    // Read bytes gathered from the first word and the word just read. A single-word
    // access sees the same word twice; bytes past its length are masked off.
    assign rd_pair = {dat_rdata, r_seg ? r_w0 : dat_rdata} >> {r_addr[1:0], 3'b000};

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign take        = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_addr      = r_addr;
        n_len       = r_len;
        n_wdata     = r_wdata;
        n_is_wr     = r_is_wr;
        n_seg       = r_seg;
        n_way       = r_way;
        n_w0        = r_w0;
        n_clr_set   = r_clr_set;
        n_fill      = r_fill;
        n_fill_line = r_fill_line;
        n_fill_cnt  = r_fill_cnt;
        n_victim    = r_victim;
        n_fill_vrow = r_fill_vrow;
        n_lfsr      = r_lfsr;
        n_res_kind  = r_res_kind;
        n_res_addr  = r_res_addr;
        n_res_len   = r_res_len;
        n_res_data  = r_res_data;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_kind  = r_out_kind;
        n_out_addr  = r_out_addr;
        n_out_len   = r_out_len;
        n_out_data  = r_out_data;
        tag_we      = 1'b0;
        tag_re      = 1'b0;
        tag_wset    = fill_set;
        tag_wtag    = r_fill_line[ADDR_W-1:TAG_SHIFT];
        dat_we      = 1'b0;
        dat_re      = 1'b0;
        dat_waddr   = mk_daddr(fill_set, r_victim, r_fill_cnt);
        dat_wdata   = i_req.fill_word;
        dat_raddr   = mk_daddr(cur_set, hit_way, cur_wrd);
        vm_we       = 1'b0;
        vm_waddr    = fill_set;
        vm_wrow     = r_fill_vrow | (NWAYS'(1) << r_victim);

        if (i_cfg.valid) begin
            n_mode = i_cfg.data;
        end

        unique case (r_state)
            S_CLR: begin
                // One set of valid bits is zeroed per cycle after reset.
                vm_we     = 1'b1;
                vm_waddr  = r_clr_set;
                vm_wrow   = '0;
                n_clr_set = r_clr_set + SET_BITS'(1);
                if (&r_clr_set) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    priority if ((i_req.action == ACT_READ || i_req.action == ACT_WRITE)
                                 && r_fill) begin
                        n_res_kind = KIND_BUSY;
                        n_res_addr = '0;
                        n_res_len  = '0;
                        n_res_data = '0;
                        n_state    = S_EMIT;
                    end else if (i_req.action == ACT_READ || i_req.action == ACT_WRITE) begin
                        n_addr  = i_req.addr;
                        n_len   = in_len;
                        n_wdata = i_req.wr_data;
                        n_is_wr = (i_req.action == ACT_WRITE);
                        n_seg   = 1'b0;
                        n_w0    = '0;
                        if (in_len == '0) begin
                            // Empty access: nothing to look up.
                            n_res_kind = (i_req.action == ACT_WRITE) ? KIND_WRITE : KIND_RDATA;
                            n_res_addr = (i_req.action == ACT_WRITE) ? i_req.addr : '0;
                            n_res_len  = '0;
                            n_res_data = (i_req.action == ACT_WRITE) ? i_req.wr_data : '0;
                            n_state    = S_EMIT;
                        end else begin
                            n_state = S_TAG;
                        end
                    end else if (i_req.action == ACT_FILL && r_fill) begin
                        dat_we     = 1'b1;
                        n_fill_cnt = r_fill_cnt + WRD_W'(1);
                        if (&r_fill_cnt) begin
                            // Last word: the line becomes valid and the read retries.
                            tag_we  = 1'b1;
                            vm_we   = 1'b1;
                            n_fill  = 1'b0;
                            n_seg   = 1'b0;
                            n_is_wr = 1'b0;
                            n_state = S_TAG;
                        end
                    end
                end
            end
            S_TAG: begin
                tag_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    dat_re  = 1'b1;
                    n_way   = hit_way;
                    n_state = S_DATA;
                end else if (!r_is_wr) begin
                    // Read miss: pick a victim, invalidate it and request the line.
                    if (has_free) begin
                        n_victim = free_way;
                    end else if (r_mode) begin
                        n_lfsr   = lfsr_step;
                        n_victim = lfsr_step[WIDX-1:0] & WIDX'(NWAYS - 1);
                    end else begin
                        n_victim = '0;
                    end
                    // The set's row is kept so the fill can mark the victim valid again.
                    vm_we       = 1'b1;
                    vm_waddr    = cur_set;
                    vm_wrow     = cur_v & ~(NWAYS'(1) << n_victim);
                    n_fill_vrow = cur_v & ~(NWAYS'(1) << n_victim);
                    n_fill      = 1'b1;
                    n_fill_cnt  = '0;
                    n_fill_line = {seg_addr[ADDR_W-1:LINE_BITS], LINE_BITS'(0)};
                    n_res_kind  = KIND_FETCH;
                    n_res_addr  = {seg_addr[ADDR_W-1:LINE_BITS], LINE_BITS'(0)};
                    n_res_len   = '0;
                    n_res_data  = '0;
                    n_state     = S_EMIT;
                end else if (two_seg && !r_seg) begin
                    n_seg   = 1'b1;
                    n_state = S_TAG;
                end else begin
                    n_res_kind = KIND_WRITE;
                    n_res_addr = r_addr;
                    n_res_len  = r_len;
                    n_res_data = r_wdata;
                    n_state    = S_EMIT;
                end
            end
            S_DATA: begin
                if (r_is_wr) begin
                    dat_we    = 1'b1;
                    dat_waddr = mk_daddr(cur_set, r_way, cur_wrd);
                    dat_wdata = merged;
                end else if (!r_seg) begin
                    n_w0 = dat_rdata;
                end
                if (two_seg && !r_seg) begin
                    n_seg   = 1'b1;
                    n_state = S_TAG;
                end else begin
                    n_res_kind = r_is_wr ? KIND_WRITE : KIND_RDATA;
                    n_res_addr = r_is_wr ? r_addr : '0;
                    n_res_len  = r_is_wr ? r_len : '0;
                    if (r_is_wr) begin
                        n_res_data = r_wdata;
                    end else begin
                        n_res_data = rd_pair[DATA_W-1:0] & rd_mask;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_addr  = r_res_addr;
                    n_out_len   = r_res_len;
                    n_out_data  = r_res_data;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_set   <= '0;
            r_mode      <= 1'b1;
            r_fill      <= 1'b0;
            r_fill_cnt  <= '0;
            r_victim    <= '0;
            r_fill_line <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
            r_seg       <= 1'b0;
            r_is_wr     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_set   <= n_clr_set;
            r_mode      <= n_mode;
            r_fill      <= n_fill;
            r_fill_cnt  <= n_fill_cnt;
            r_victim    <= n_victim;
            r_fill_line <= n_fill_line;
            r_lfsr      <= n_lfsr;
            r_out_valid <= n_out_valid;
            r_seg       <= n_seg;
            r_is_wr     <= n_is_wr;
        end
    end

    // Valid-bit memory: written by the clearing pass, a read miss and the last fill word.
    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            valid_mem[vm_waddr] <= vm_wrow;
        end
        if (tag_re) begin
            r_vrow <= valid_mem[cur_set];
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_len       <= n_len;
        r_wdata     <= n_wdata;
        r_way       <= n_way;
        r_w0        <= n_w0;
        r_fill_vrow <= n_fill_vrow;
        r_res_kind  <= n_res_kind;
        r_res_addr  <= n_res_addr;
        r_res_len   <= n_res_len;
        r_res_data  <= n_res_data;
        r_out_kind  <= n_out_kind;
        r_out_addr  <= n_out_addr;
        r_out_len   <= n_out_len;
        r_out_data  <= n_out_data;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.kind     = r_out_kind;
    assign o_rsp.out_addr = r_out_addr;
    assign o_rsp.out_len  = r_out_len;
    assign o_rsp.out_data = r_out_data;

    sawtc_tag_ram #(
        .SB(SET_BITS), .NW(NWAYS), .WB(WIDX), .TW(TAG_W)
    ) u_tag (
        .i_clk (i_clk),
        .i_we  (tag_we),
        .i_wset(tag_wset),
        .i_wway(r_victim),
        .i_wtag(tag_wtag),
        .i_re  (tag_re),
        .i_rset(cur_set),
        .o_row (tag_row)
    );

    sawtc_data_ram #(
        .AW(DA_W)
    ) u_data (
        .i_clk  (i_clk),
        .i_we   (dat_we),
        .i_waddr(dat_waddr),
        .i_wdata(dat_wdata),
        .i_re   (dat_re),
        .i_raddr(dat_raddr),
        .o_rdata(dat_rdata)
    );
endmodule

>>> design/sawtc_checker.sv
// Port-level checks of the cache core, attached to it by the bind below.
// Depends on sawtc_pkg and on the core's channel ports.
module sawtc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic [1:0] i_req_action,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_kind,
    input logic [31:0] i_rsp_data
);
    import sawtc_pkg::*;

    // A result that is not taken stays on the port with its kind and data unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_kind) &&
        $stable(i_rsp_data))
        else $error("response changed while stalled");

    // Reset empties the output register.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // A read or write always occupies the core for at least the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready &&
        (i_req_action == ACT_READ || i_req_action == ACT_WRITE) |=> !i_req_ready)
        else $error("access accepted back to back");
endmodule

bind set_assoc_write_through_cache_core sawtc_checker u_sawtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_action(i_req.action),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_kind  (o_rsp.kind),
    .i_rsp_data  (o_rsp.out_data)
);
